// File: rtl/core/rrip_avs_pkg.sv
// Shared constants, types and request/result records for the RRIP age keeper.
`default_nettype none

package rrip_avs_pkg;

    localparam int WAYS  = 16;
    localparam int SETS  = 64;

    localparam int AGE_W     = 3;
    localparam int SET_IDX_W = 6;
    localparam int WAY_IDX_W = 4;
    localparam int ROW_W     = WAYS * AGE_W;

    // Only SET_IDX_W bits of set number reach the block, so rows past 64 are never used.
    localparam int MEM_DEPTH = (SETS > (1 << SET_IDX_W)) ? (1 << SET_IDX_W) : SETS;
    localparam int SET_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic [AGE_W-1:0] AGE_AVERSE   = 3'd7;
    localparam logic [AGE_W-1:0] AGE_FRIENDLY = 3'd0;
    localparam logic [AGE_W-1:0] AGE_SAT      = 3'd6;

    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic                 req_type;
        logic [SET_IDX_W-1:0] set_index;
        logic [WAY_IDX_W-1:0] way;
        logic                 averse;
        logic                 is_hit;
    } t_req;

    typedef struct packed {
        logic                 wr_en;
        t_row                 row;
        logic [WAY_IDX_W-1:0] victim_way;
        logic [AGE_W-1:0]     victim_age;
    } t_calc;

endpackage

`default_nettype wire

// File: rtl/core/rrip_avs_calc.sv
// Combinational age update and victim search over one set's age row.
`default_nettype none

module rrip_avs_calc (
    input  rrip_avs_pkg::t_req  i_req,
    input  rrip_avs_pkg::t_row  i_row,
    output rrip_avs_pkg::t_calc o_res
);
    import rrip_avs_pkg::*;

    logic                 set_ok;
    logic                 way_ok;
    logic [7:0]           age_seen;
    logic [AGE_W-1:0]     max_age;
    logic [WAYS-1:0]      at_max;
    logic [WAY_IDX_W-1:0] vway;
    t_row                 new_row;
    logic [AGE_W-1:0]     age_i;

    assign set_ok = int'(i_req.set_index) < SETS;
    assign way_ok = int'(i_req.way) < WAYS;

    always_comb begin
        new_row = i_row;
        for (int i = 0; i < WAYS; i++) begin
            age_i = i_row[i*AGE_W +: AGE_W];
            if (i == int'(i_req.way)) begin
                new_row[i*AGE_W +: AGE_W] = i_req.averse ? AGE_AVERSE : AGE_FRIENDLY;
            end else if (!i_req.averse && !i_req.is_hit && (age_i < AGE_SAT)) begin
                new_row[i*AGE_W +: AGE_W] = age_i + 3'd1;
            end
        end
    end

    // Find the highest age present, then the lowest way holding it.
    always_comb begin
        age_seen = '0;
        for (int i = 0; i < WAYS; i++) begin
            age_seen[i_row[i*AGE_W +: AGE_W]] = 1'b1;
        end
        max_age = '0;
        for (int a = 0; a < 8; a++) begin
            if (age_seen[a]) begin
                max_age = AGE_W'(a);
            end
        end
        for (int i = 0; i < WAYS; i++) begin
            at_max[i] = (i_row[i*AGE_W +: AGE_W] == max_age);
        end
        vway = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (at_max[i]) begin
                vway = WAY_IDX_W'(i);
            end
        end
    end

    always_comb begin
        o_res.wr_en      = (i_req.req_type == REQ_UPDATE) && set_ok && way_ok;
        o_res.row        = new_row;
        o_res.victim_way = '0;
        o_res.victim_age = '0;
        if ((i_req.req_type == REQ_VICTIM) && set_ok) begin
            o_res.victim_way = vway;
            o_res.victim_age = max_age;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rrip_age_update_victim_select.sv
// Top level: age row memory, request pipeline and result register.
`default_nettype none

// RRIP re-reference age keeper. Each transaction is either a victim query
// (returns the lowest way holding the highest age in the set) or an age update
// (returns zeros). One transaction is accepted per cycle while o_stall is low.
// The first stage reads the set's age row from the single read/write row
// memory into a register; the second updates it or searches it and loads the
// result register. A back-to-back update of the same set is forwarded around
// the memory. Reset clears all ages at once through per-set valid flags, so no
// clearing pass is needed and the block takes requests right after reset.
module rrip_age_update_victim_select (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  wire                                   i_req_type,
    input  wire  [rrip_avs_pkg::SET_IDX_W-1:0]    i_set_index,
    input  wire  [rrip_avs_pkg::WAY_IDX_W-1:0]    i_way,
    input  wire                                   i_averse,
    input  wire                                   i_is_hit,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output logic [rrip_avs_pkg::WAY_IDX_W-1:0]    o_victim_way,
    output logic [rrip_avs_pkg::AGE_W-1:0]        o_victim_age
);
    import rrip_avs_pkg::*;

    t_row                 r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_row_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;
    logic                 r_fwd;
    t_row                 r_fwd_row;

    logic                 r_s1_vld;
    t_req                 r_s1;
    logic                 r_out_vld;
    logic [WAY_IDX_W-1:0] r_out_way;
    logic [AGE_W-1:0]     r_out_age;

    logic                 adv;
    logic                 wr;
    logic [SET_W-1:0]     rd_addr;
    logic [SET_W-1:0]     wr_addr;
    logic                 rd_ok;
    t_row                 row_cur;
    t_calc                res;

    assign adv     = !r_out_vld || !i_stall;
    assign o_stall = !adv;
    assign rd_addr = i_set_index[SET_W-1:0];
    assign wr_addr = r_s1.set_index[SET_W-1:0];
    assign rd_ok   = int'(i_set_index) < MEM_DEPTH;
    assign row_cur = r_fwd ? r_fwd_row : (r_rd_vld ? r_rd_data : '0);
    assign wr      = r_s1_vld && adv && res.wr_en;

    rrip_avs_calc u_calc (
        .i_req (r_s1),
        .i_row (row_cur),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr) begin
            r_mem[wr_addr] <= res.row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_fwd     <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (adv) begin
                r_s1_vld  <= i_valid;
                r_out_vld <= r_s1_vld;
                r_rd_vld  <= rd_ok && r_row_vld[rd_addr];
                // Catch the row being written on the same edge as this read.
                r_fwd     <= wr && (wr_addr == rd_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= '{req_type:     i_req_type,
                           set_index:    i_set_index,
                           way:          i_way,
                           averse:       i_averse,
                           is_hit:       i_is_hit};
            r_fwd_row <= res.row;
            r_out_way <= res.victim_way;
            r_out_age <= res.victim_age;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_victim_way = r_out_way;
    assign o_victim_age = r_out_age;

endmodule

`default_nettype wire
